// ----- rtl/core/bpc_pkg.sv -----
package bpc_pkg;

   localparam int unsigned TimeWidth     = 32;
   localparam int unsigned DebounceWidth = 16;
   localparam int unsigned CsrAddrWidth  = 4;
   localparam int unsigned CsrDataWidth  = 32;
   localparam int unsigned ReqDataWidth  = 40;
   localparam int unsigned RspDataWidth  = 8;

   localparam logic [DebounceWidth-1:0] DebounceReset  = 16'd50;
   localparam logic [TimeWidth-1:0]     LongPressReset = 32'd2000;
   localparam logic [TimeWidth-1:0]     CooldownReset  = 32'd30000;

   typedef enum logic [1:0] {
      REG_DEBOUNCE   = 2'd0,
      REG_LONG_PRESS = 2'd1,
      REG_COOLDOWN   = 2'd2,
      REG_NONE       = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      RES_NONE     = 2'd0,
      RES_ACCEPTED = 2'd1,
      RES_BUSY     = 2'd2,
      RES_COOLDOWN = 2'd3
   } result_type;

   typedef struct packed {
      logic [DebounceWidth-1:0] debounce_time;
      logic [TimeWidth-1:0]     long_press_time;
      logic [TimeWidth-1:0]     request_cooldown;
   } config_type;

   typedef struct packed {
      logic                 raw_pressed;
      logic [TimeWidth-1:0] now_ms;
      logic                 system_idle;
   } poll_type;

   typedef struct packed {
      logic       pressed_stable;
      logic       mute_pulse;
      result_type long_press_result;
      logic       manual_request;
   } verdict_type;

endpackage

// ----- rtl/core/bpc_csr.sv -----
module bpc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bpc_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [bpc_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [bpc_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                               csr_pready,
   output bpc_pkg::config_type                cfg
);
   import bpc_pkg::*;

   config_type    cfg_ff;
   config_type    cfg_in;
   reg_index_type index;
   logic          write_en;

   assign index    = reg_index_type'(csr_paddr[CsrAddrWidth-1:2]);
   assign write_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_DEBOUNCE:   cfg_in.debounce_time    = csr_pwdata[DebounceWidth-1:0];
            REG_LONG_PRESS: cfg_in.long_press_time  = csr_pwdata[TimeWidth-1:0];
            REG_COOLDOWN:   cfg_in.request_cooldown = csr_pwdata[TimeWidth-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time    <= DebounceReset;
         cfg_ff.long_press_time  <= LongPressReset;
         cfg_ff.request_cooldown <= CooldownReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (index)
         REG_DEBOUNCE:   csr_prdata = {{(CsrDataWidth-DebounceWidth){1'b0}},
                                       cfg_ff.debounce_time};
         REG_LONG_PRESS: csr_prdata = cfg_ff.long_press_time;
         REG_COOLDOWN:   csr_prdata = cfg_ff.request_cooldown;
         default:        csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

// ----- rtl/core/bpc_classify.sv -----
module bpc_classify (
   input  logic                 clock,
   input  logic                 reset,
   input  bpc_pkg::config_type  cfg,
   input  bpc_pkg::poll_type    poll,
   input  logic                 step,
   output bpc_pkg::verdict_type verdict
);
   import bpc_pkg::*;

   logic                 stable_ff,       stable_in;
   logic                 last_raw_ff,     last_raw_in;
   logic                 handled_ff,      handled_in;
   logic [TimeWidth-1:0] change_time_ff,  change_time_in;
   logic [TimeWidth-1:0] press_start_ff,  press_start_in;
   logic [TimeWidth-1:0] last_req_ff,     last_req_in;

   logic [TimeWidth-1:0] since_change;
   logic [TimeWidth-1:0] since_press;
   logic [TimeWidth-1:0] since_req;
   logic                 settle;
   logic                 long_hit;
   logic                 cooled;

   always_comb begin
      last_raw_in    = poll.raw_pressed;
      change_time_in = (poll.raw_pressed != last_raw_ff) ? poll.now_ms : change_time_ff;
      since_change   = poll.now_ms - change_time_in;
      settle         = (poll.raw_pressed != stable_ff) &&
                       (since_change >= {{(TimeWidth-DebounceWidth){1'b0}},
                                         cfg.debounce_time});

      stable_in      = stable_ff;
      press_start_in = press_start_ff;
      handled_in     = handled_ff;
      last_req_in    = last_req_ff;
      verdict        = '0;

      if (settle) begin
         stable_in = poll.raw_pressed;
         if (poll.raw_pressed) begin
            press_start_in = poll.now_ms;
            handled_in     = 1'b0;
         end else if (!handled_ff) begin
            verdict.mute_pulse = 1'b1;
         end
      end

      // long press test sees this poll's debounce outcome
      since_press = poll.now_ms - press_start_in;
      since_req   = poll.now_ms - last_req_ff;
      long_hit    = stable_in && !handled_in && (since_press >= cfg.long_press_time);
      // zero last-request time means no request yet
      cooled      = (last_req_ff == '0) || (since_req >= cfg.request_cooldown);

      if (long_hit) begin
         handled_in = 1'b1;
         priority if (!poll.system_idle) begin
            verdict.long_press_result = RES_BUSY;
         end else if (!cooled) begin
            verdict.long_press_result = RES_COOLDOWN;
         end else begin
            verdict.long_press_result = RES_ACCEPTED;
            verdict.manual_request    = 1'b1;
            last_req_in               = poll.now_ms;
         end
      end

      verdict.pressed_stable = stable_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff      <= 1'b0;
         last_raw_ff    <= 1'b0;
         handled_ff     <= 1'b0;
         change_time_ff <= '0;
         press_start_ff <= '0;
         last_req_ff    <= '0;
      end else if (step) begin
         stable_ff      <= stable_in;
         last_raw_ff    <= last_raw_in;
         handled_ff     <= handled_in;
         change_time_ff <= change_time_in;
         press_start_ff <= press_start_in;
         last_req_ff    <= last_req_in;
      end
   end

endmodule

// ----- rtl/core/button_press_classifier_unit.sv -----
// Button press classifier: each item on req_ is one poll of a push button (raw level,
// millisecond timestamp, sequencer idle flag) and yields exactly one item on rsp_ with the
// debounced level, a mute pulse for a short press, the long-press verdict and a manual
// request pulse. Polls pass through an input register and a result register with all the
// classification done combinationally between them, so the block takes one poll per clock;
// a result waits in the result register until rsp_tready takes it; the only limit on rate
// is rsp_tready. The user must write the timing registers over the APB-style csr_ port
// only while idle; the block itself does not enforce this.
module button_press_classifier_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [0] raw_pressed, [32:1] now_ms, [33] system_idle, [39:34] zero
   input  logic [bpc_pkg::ReqDataWidth-1:0]  req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] pressed_stable, [1] mute_pulse, [3:2] long_press_result, [4] manual_request,
   // [7:5] zero
   output logic [bpc_pkg::RspDataWidth-1:0]  rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bpc_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [bpc_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [bpc_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import bpc_pkg::*;

   config_type  cfg;
   poll_type    poll_ff;
   logic        poll_valid_ff;
   verdict_type verdict;
   verdict_type rsp_ff;
   logic        rsp_valid_ff;
   logic        advance;
   logic        out_free;

   bpc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // item moves from the input register to the result register
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = poll_valid_ff && out_free;
   assign req_tready = !poll_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_valid_ff <= 1'b0;
      end else if (req_tready) begin
         poll_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         poll_ff.raw_pressed <= req_tdata[0];
         poll_ff.now_ms      <= req_tdata[TimeWidth:1];
         poll_ff.system_idle <= req_tdata[TimeWidth+1];
      end
   end

   bpc_classify u_classify (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .poll    (poll_ff),
      .step    (advance),
      .verdict (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= poll_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= verdict;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.manual_request, rsp_ff.long_press_result,
                        rsp_ff.mute_pulse, rsp_ff.pressed_stable};

endmodule

// ----- test/press_verdict_monitor.sv -----
module press_verdict_monitor (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [bpc_pkg::ReqDataWidth-1:0]  req_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [bpc_pkg::RspDataWidth-1:0]  rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bpc_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [bpc_pkg::CsrDataWidth-1:0]  csr_pwdata,
   input  logic [bpc_pkg::CsrDataWidth-1:0]  csr_prdata,
   input  logic                              csr_pready,
   output int                                fail_count,
   output int                                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [bpc_pkg::DebounceWidth-1:0] debounce_ms;
   logic [bpc_pkg::TimeWidth-1:0]     long_press_ms;
   logic [bpc_pkg::TimeWidth-1:0]     cooldown_ms;

   logic                          stable_lvl;
   logic                          last_raw;
   logic                          long_done;
   logic [bpc_pkg::TimeWidth-1:0] raw_change_ms;
   logic [bpc_pkg::TimeWidth-1:0] press_start_ms;
   logic [bpc_pkg::TimeWidth-1:0] last_request_ms;

   bpc_pkg::verdict_type verdicts_due[$];
   int errors = 0;

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic classify_poll(input logic raw, input logic [bpc_pkg::TimeWidth-1:0] now,
                                input logic idle, output bpc_pkg::verdict_type verdict);
      logic [bpc_pkg::TimeWidth-1:0] since_change;
      logic [bpc_pkg::TimeWidth-1:0] held_ms;
      logic [bpc_pkg::TimeWidth-1:0] since_request;
      logic                          cooled;
      verdict = '0;
      verdict.long_press_result = bpc_pkg::RES_NONE;
      if (raw != last_raw) begin
         last_raw = raw;
         raw_change_ms = now;
      end
      since_change = now - raw_change_ms;
      if (raw != stable_lvl && since_change >= {16'd0, debounce_ms}) begin
         stable_lvl = raw;
         if (stable_lvl) begin
            press_start_ms = now;
            long_done = 1'b0;
         end else if (!long_done) begin
            verdict.mute_pulse = 1'b1;
         end
      end
      held_ms = now - press_start_ms;
      if (stable_lvl && !long_done && held_ms >= long_press_ms) begin
         // zero as last request time reads as never requested
         since_request = now - last_request_ms;
         cooled = (last_request_ms == '0) || (since_request >= cooldown_ms);
         long_done = 1'b1;
         if (!idle) begin
            verdict.long_press_result = bpc_pkg::RES_BUSY;
         end else if (!cooled) begin
            verdict.long_press_result = bpc_pkg::RES_COOLDOWN;
         end else begin
            last_request_ms = now;
            verdict.long_press_result = bpc_pkg::RES_ACCEPTED;
            verdict.manual_request = 1'b1;
         end
      end
      verdict.pressed_stable = stable_lvl;
   endtask

   always @(posedge clock) begin
      bpc_pkg::verdict_type          want;
      bpc_pkg::verdict_type          got;
      bpc_pkg::reg_index_type        reg_sel;
      logic [bpc_pkg::CsrDataWidth-1:0] reg_value;
      reg_sel = bpc_pkg::reg_index_type'(csr_paddr[3:2]);
      if (reset) begin
         debounce_ms     = bpc_pkg::DebounceReset;
         long_press_ms   = bpc_pkg::LongPressReset;
         cooldown_ms     = bpc_pkg::CooldownReset;
         stable_lvl      = 1'b0;
         last_raw        = 1'b0;
         long_done       = 1'b0;
         raw_change_ms   = '0;
         press_start_ms  = '0;
         last_request_ms = '0;
         verdicts_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.pressed_stable    = rsp_tdata[0];
            got.mute_pulse        = rsp_tdata[1];
            got.long_press_result = bpc_pkg::result_type'(rsp_tdata[3:2]);
            got.manual_request    = rsp_tdata[4];
            if (verdicts_due.size() == 0) begin
               $display("%0t unexpected item: expected none, actual %0h", $time, rsp_tdata);
               errors++;
            end else begin
               want = verdicts_due.pop_front();
               check_field("pressed_stable", want.pressed_stable, got.pressed_stable);
               check_field("mute_pulse", want.mute_pulse, got.mute_pulse);
               check_field("long_press_result", want.long_press_result,
                           got.long_press_result);
               check_field("manual_request", want.manual_request, got.manual_request);
               check_field("rsp_tdata padding", 0, rsp_tdata[7:5]);
            end
         end
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (reg_sel)
                  bpc_pkg::REG_DEBOUNCE:   debounce_ms   = csr_pwdata[15:0];
                  bpc_pkg::REG_LONG_PRESS: long_press_ms = csr_pwdata;
                  bpc_pkg::REG_COOLDOWN:   cooldown_ms   = csr_pwdata;
                  default: ;
               endcase
            end else if (reg_sel != bpc_pkg::REG_NONE) begin
               case (reg_sel)
                  bpc_pkg::REG_DEBOUNCE:   reg_value = {16'd0, debounce_ms};
                  bpc_pkg::REG_LONG_PRESS: reg_value = long_press_ms;
                  default:                 reg_value = cooldown_ms;
               endcase
               if (csr_prdata !== reg_value) begin
                  $display("%0t register %0d read: expected %0h, actual %0h", $time,
                           reg_sel, reg_value, csr_prdata);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            classify_poll(req_tdata[0], req_tdata[32:1], req_tdata[33], want);
            verdicts_due.push_back(want);
         end
      end
      fail_count <= errors;
      pending    <= verdicts_due.size();
   end

endmodule

// ----- test/button_press_classifier_unit_tb.sv -----
module button_press_classifier_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bpc_pkg::*;

   localparam int CycleLimit = 400000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // [0] raw_pressed, [32:1] now_ms, [33] system_idle, [39:34] zero
   logic [ReqDataWidth-1:0]  req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // [0] pressed_stable, [1] mute_pulse, [3:2] long_press_result, [4] manual_request
   logic [RspDataWidth-1:0]  rsp_tdata;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0]  csr_paddr = '0;
   logic [CsrDataWidth-1:0]  csr_pwdata = '0;
   logic [CsrDataWidth-1:0]  csr_prdata;
   logic                     csr_pready;

   int                       fail_count;
   int                       pending;

   logic [TimeWidth-1:0]     clock_ms = '0;
   int                       step_max = 10;
   int                       items_sent = 0;
   bit                       gaps_on = 1'b1;
   bit                       hold_request = 1'b0;

   button_press_classifier_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   press_verdict_monitor verdict_monitor (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   // result side: random stalls, a long hold-off on request
   initial begin
      @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
         end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(0, 5) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 8))
               @(posedge clock);
         end
      end
   end

   function automatic logic [TimeWidth-1:0] next_ms();
      clock_ms = clock_ms + TimeWidth'($urandom_range(0, step_max));
      return clock_ms;
   endfunction

   task automatic send_poll(input logic raw, input logic [TimeWidth-1:0] now, input logic idle);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, idle, now, raw};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic csr_access(input logic write, input reg_index_type idx,
                             input logic [CsrDataWidth-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_timing(input logic [DebounceWidth-1:0] debounce,
                             input logic [TimeWidth-1:0] long_press,
                             input logic [TimeWidth-1:0] cooldown);
      // upper bits of the debounce word are dropped by the block
      csr_access(1'b1, REG_DEBOUNCE, {16'($urandom), debounce});
      csr_access(1'b1, REG_LONG_PRESS, long_press);
      csr_access(1'b1, REG_COOLDOWN, cooldown);
      csr_access(1'b0, REG_DEBOUNCE, '0);
      csr_access(1'b0, REG_LONG_PRESS, '0);
      csr_access(1'b0, REG_COOLDOWN, '0);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // bounce, hold, bounce, release with a random time base
   task automatic press_sequence();
      logic idle;
      idle = ($urandom_range(0, 4) != 0);
      repeat ($urandom_range(0, 3)) send_poll(1'($urandom_range(0, 1)), next_ms(), idle);
      repeat ($urandom_range(1, 12)) send_poll(1'b1, next_ms(), idle);
      repeat ($urandom_range(0, 3))
         send_poll(1'($urandom_range(0, 1)), next_ms(), $urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 6)) send_poll(1'b0, next_ms(), idle);
   endtask

   initial begin
      logic [DebounceWidth-1:0] debounce;
      logic [TimeWidth-1:0]     long_press;
      logic [TimeWidth-1:0]     cooldown;
      int                       target;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_access(1'b0, REG_DEBOUNCE, '0);
      csr_access(1'b0, REG_LONG_PRESS, '0);
      csr_access(1'b0, REG_COOLDOWN, '0);
      csr_access(1'b1, REG_NONE, 32'hFFFF_FFFF);

      // zero debounce and long press, request at time zero reads as never
      set_timing(16'd0, 32'd0, 32'hFFFF_FFFF);
      send_poll(1'b1, 32'd0, 1'b1);
      send_poll(1'b0, 32'd1, 1'b1);
      send_poll(1'b1, 32'd2, 1'b1);
      send_poll(1'b0, 32'd3, 1'b1);
      send_poll(1'b1, 32'd4, 1'b1);
      send_poll(1'b0, 32'd5, 1'b1);
      drain();

      set_timing(DebounceReset, LongPressReset, CooldownReset);
      send_poll(1'b0, 32'd100000, 1'b1);
      send_poll(1'b1, 32'd100010, 1'b1);
      send_poll(1'b1, 32'd100059, 1'b1);
      send_poll(1'b1, 32'd100060, 1'b1);
      send_poll(1'b1, 32'd102059, 1'b1);
      send_poll(1'b1, 32'd102060, 1'b1);
      send_poll(1'b0, 32'd102100, 1'b1);
      send_poll(1'b0, 32'd102150, 1'b1);
      send_poll(1'b1, 32'd103000, 1'b0);
      send_poll(1'b1, 32'd103050, 1'b0);
      send_poll(1'b1, 32'd105050, 1'b0);
      send_poll(1'b0, 32'd105100, 1'b0);
      send_poll(1'b0, 32'd105150, 1'b1);
      send_poll(1'b1, 32'd106000, 1'b1);
      send_poll(1'b1, 32'd106050, 1'b1);
      send_poll(1'b0, 32'd106060, 1'b1);
      send_poll(1'b0, 32'd106110, 1'b1);
      send_poll(1'b1, 32'd110000, 1'b1);
      send_poll(1'b1, 32'd110050, 1'b1);
      send_poll(1'b1, 32'd112050, 1'b1);
      drain();

      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin debounce = 16'd5;     long_press = 32'd40;     cooldown = 32'd200;
                     step_max = 10; end
            1: begin debounce = 16'd0;     long_press = 32'd0;      cooldown = 32'd0;
                     step_max = 5; end
            2: begin debounce = 16'd20;    long_press = 32'd100;    cooldown = 32'd1000;
                     step_max = 30; end
            3: begin debounce = 16'hFFFF;  long_press = 32'd131072; cooldown = 32'd0;
                     step_max = 30000; end
            4: begin debounce = 16'd3;     long_press = 32'd20;
                     cooldown = 32'hFFFF_FFFF; step_max = 8; end
            5: begin debounce = 16'd0;     long_press = 32'hFFFF_FFFF; cooldown = 32'd50;
                     step_max = 4; end
            default: begin
               debounce   = DebounceWidth'($urandom_range(0, 30));
               long_press = $urandom_range(0, 200);
               cooldown   = $urandom_range(0, 2000);
               step_max   = 20;
               gaps_on    = 1'b0;
            end
         endcase
         set_timing(debounce, long_press, cooldown);
         clock_ms = (phase % 2 == 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 500);
         if (phase == 2) hold_request = 1'b1;
         target = items_sent + 140;
         while (items_sent < target) begin
            if ($urandom_range(0, 6) == 0)
               send_poll(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
            else
               press_sequence();
         end
         drain();
      end

      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
